>>> rtl/mtt_pkg.sv
package mtt_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned ACT_W    = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned ENTRY_W  = TIME_W + ACT_W;

    localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_EV
    } state_t;

endpackage

>>> rtl/mtt_ram.sv
module mtt_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/multi_timer_table.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    func, delay, action_id
// out      output     out_valid/out_stall  kind, fired_action, last, pending_count, next_deadline
//
// add and tick with nothing due are handled in idle without leaving it
// a due tick makes two passes over the n stored timers, and a stalled output can hold it:
// one pass over the table ram finds the minimum and keep count, a second pass
// reads each entry again, fires or compacts it (one ram port read, one write)
// rst_n is asynchronous; the table ram holds no reset and only its entries below the count are used
// a stalled output holds the sequencer on the current entry
module multi_timer_table #(
    parameter int unsigned TIMER_SLOTS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     func,
    input  logic [mtt_pkg::DELAY_W-1:0]              delay,
    input  logic [mtt_pkg::ACT_W-1:0]                action_id,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [mtt_pkg::KIND_W-1:0]               kind,
    output logic [mtt_pkg::ACT_W-1:0]                fired_action,
    output logic                                     last,
    output logic [$clog2(TIMER_SLOTS+1)-1:0]         pending_count,
    output logic [mtt_pkg::TIME_W-1:0]               next_deadline
);

    localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);
    localparam int unsigned IDX_W = $clog2(TIMER_SLOTS);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

    mtt_pkg::state_t state_reg, state_next;

    logic [mtt_pkg::TIME_W-1:0] time_reg, time_next;
    logic [mtt_pkg::TIME_W-1:0] earliest_reg, earliest_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]           keep_reg, keep_next;
    logic [CNT_W-1:0]           fired_seen_reg, fired_seen_next;
    logic [mtt_pkg::TIME_W-1:0] min_reg, min_next;
    logic                       data_vld_reg, data_vld_next;

    logic                        out_valid_reg, out_valid_next;
    logic [mtt_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [mtt_pkg::ACT_W-1:0]   action_reg, action_next;
    logic                        last_reg, last_next;
    logic [CNT_W-1:0]            pending_reg, pending_next;
    logic [mtt_pkg::TIME_W-1:0]  deadline_reg, deadline_next;

    logic                         ram_wr_en;
    logic [IDX_W-1:0]             ram_wr_addr;
    logic [mtt_pkg::ENTRY_W-1:0]  ram_wr_data;
    logic [mtt_pkg::ENTRY_W-1:0]  ram_rd_data;
    logic [mtt_pkg::TIME_W-1:0]   rd_deadline;
    logic [mtt_pkg::ACT_W-1:0]    rd_action;

    logic                         out_free;
    logic                         in_take;
    logic [mtt_pkg::TIME_W:0]     add_sum;
    logic [mtt_pkg::TIME_W-1:0]   add_deadline;
    logic [mtt_pkg::TIME_W-1:0]   tick_time;
    logic                         tick_due;
    logic                         entry_due;
    logic [CNT_W-1:0]             fire_total;

    mtt_ram #(
        .WIDTH (mtt_pkg::ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_deadline = ram_rd_data[mtt_pkg::ENTRY_W-1:mtt_pkg::ACT_W];
    assign rd_action   = ram_rd_data[mtt_pkg::ACT_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == mtt_pkg::ST_IDLE) && out_free);
    assign in_take  = in_valid && !in_stall;

    assign add_sum      = {1'b0, time_reg} + (mtt_pkg::TIME_W + 1)'(delay);
    assign add_deadline = add_sum[mtt_pkg::TIME_W] ? mtt_pkg::ALL_ONES
                                                   : add_sum[mtt_pkg::TIME_W-1:0];
    assign tick_time    = (time_reg == mtt_pkg::ALL_ONES) ? time_reg
                                                          : time_reg + mtt_pkg::TIME_W'(1);
    assign tick_due     = (count_reg != '0) && (tick_time >= earliest_reg);
    assign entry_due    = rd_deadline <= time_reg;
    assign fire_total   = count_reg - keep_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtt_pkg::ST_IDLE:
            begin
                if (in_take && (func == mtt_pkg::FUNC_TICK) && tick_due)
                begin
                    state_next = mtt_pkg::ST_SCAN;
                end
            end
            mtt_pkg::ST_SCAN:
            begin
                if (!data_vld_reg && (idx_reg == count_reg))
                begin
                    state_next = mtt_pkg::ST_RD;
                end
            end
            mtt_pkg::ST_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = mtt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mtt_pkg::ST_EV;
                end
            end
            mtt_pkg::ST_EV:
            begin
                if (!entry_due || out_free)
                begin
                    state_next = mtt_pkg::ST_RD;
                end
            end
            default:
            begin
                state_next = mtt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        time_next       = time_reg;
        earliest_next   = earliest_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        keep_next       = keep_reg;
        fired_seen_next = fired_seen_reg;
        min_next        = min_reg;
        data_vld_next   = 1'b0;

        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        action_next     = action_reg;
        last_next       = last_reg;
        pending_next    = pending_reg;
        deadline_next   = deadline_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_ptr_reg[IDX_W-1:0];
        ram_wr_data = ram_rd_data;

        case (state_reg)
            mtt_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (func == mtt_pkg::FUNC_ADD)
                    begin
                        out_valid_next = 1'b1;
                        action_next    = '0;
                        last_next      = 1'b1;
                        if (count_reg >= SLOTS_C)
                        begin
                            kind_next     = mtt_pkg::KIND_REJECTED;
                            pending_next  = count_reg;
                            deadline_next = earliest_reg;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = count_reg[IDX_W-1:0];
                            ram_wr_data = {add_deadline, action_id};
                            count_next  = count_reg + CNT_W'(1);
                            if (add_deadline < earliest_reg)
                            begin
                                earliest_next = add_deadline;
                            end
                            kind_next     = mtt_pkg::KIND_ADDED;
                            pending_next  = count_next;
                            deadline_next = earliest_next;
                        end
                    end
                    else
                    begin
                        time_next = tick_time;
                        idx_next  = '0;
                        keep_next = '0;
                        min_next  = mtt_pkg::ALL_ONES;
                    end
                end
            end
            mtt_pkg::ST_SCAN:
            begin
                if (data_vld_reg && !entry_due)
                begin
                    keep_next = keep_reg + CNT_W'(1);
                    if (rd_deadline < min_reg)
                    begin
                        min_next = rd_deadline;
                    end
                end
                if (idx_reg != count_reg)
                begin
                    idx_next      = idx_reg + CNT_W'(1);
                    data_vld_next = 1'b1;
                end
                else if (!data_vld_reg)
                begin
                    idx_next        = '0;
                    wr_ptr_next     = '0;
                    fired_seen_next = '0;
                end
            end
            mtt_pkg::ST_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next    = keep_reg;
                    earliest_next = min_reg;
                end
            end
            mtt_pkg::ST_EV:
            begin
                if (entry_due)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        kind_next       = mtt_pkg::KIND_FIRED;
                        action_next     = rd_action;
                        last_next       = (fired_seen_reg + CNT_W'(1)) == fire_total;
                        pending_next    = keep_reg;
                        deadline_next   = min_reg;
                        fired_seen_next = fired_seen_reg + CNT_W'(1);
                        idx_next        = idx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    ram_wr_en   = 1'b1;
                    wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    idx_next    = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mtt_pkg::ST_IDLE;
            time_reg       <= '0;
            earliest_reg   <= mtt_pkg::ALL_ONES;
            count_reg      <= '0;
            idx_reg        <= '0;
            wr_ptr_reg     <= '0;
            keep_reg       <= '0;
            fired_seen_reg <= '0;
            data_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            earliest_reg   <= earliest_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            wr_ptr_reg     <= wr_ptr_next;
            keep_reg       <= keep_next;
            fired_seen_reg <= fired_seen_next;
            data_vld_reg   <= data_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg      <= min_next;
        kind_reg     <= kind_next;
        action_reg   <= action_next;
        last_reg     <= last_next;
        pending_reg  <= pending_next;
        deadline_reg <= deadline_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign fired_action  = action_reg;
    assign last          = last_reg;
    assign pending_count = pending_reg;
    assign next_deadline = deadline_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_C)
        else $error("entry count above table size");

    a_due_tick_fires: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtt_pkg::ST_SCAN && state_next == mtt_pkg::ST_RD) |-> keep_reg < count_reg)
        else $error("due tick found nothing to fire");

    a_fired_all: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtt_pkg::ST_RD && idx_reg == count_reg) |-> fired_seen_reg == fire_total)
        else $error("compaction ended with fired count mismatch");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtt_pkg::ST_EV) |-> (wr_ptr_reg <= idx_reg && idx_reg < count_reg))
        else $error("compaction write pointer ahead of read index");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtt_pkg::ST_SCAN) |=> (state_reg != mtt_pkg::ST_IDLE))
        else $error("scan pass skipped the fire pass");

endmodule
